/* sv/firfc_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the fixed-point fir filter
package firfc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned TapIdxW = 8;
  localparam int unsigned AccW    = 32;
  localparam int unsigned OutShift = 12;

  localparam logic FuncSample = 1'b0;
  localparam logic FuncCoeff  = 1'b1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic                 push;
    logic                 rot;
    logic                 wr;
    logic [TapIdxW-1:0]   wr_idx;
    sample_t              wr_value;
  } ctrl_t;

endpackage

/* sv/fir_filter_fixed_point_circular.sv */
`timescale 1ns / 1ps
// fir filter top level: ring of tap cells, shared multiply-accumulate head
//
// A sample word (tuser 0) shifts into a row of TAPS cells, each holding one
// delayed sample and one coefficient. The ring then rotates once round, one
// cell per cycle, past a single 16x16 multiplier and a 32-bit accumulator at
// its head, the one multiplier serving every tap. The result is bits 27..12 of
// the wrapped sum and waits in an output register; the next word may be
// taken while it waits. A coefficient word (tuser 1) loads tap coeff_index
// and gives no result; indexes at or above TAPS are ignored. All samples and
// coefficients reset to zero.
module fir_filter_fixed_point_circular #(
  parameter int unsigned TAPS = 71
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // sample_in, coeff_index, coeff_value, zero pad
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // filtered_out
);

  localparam int unsigned CntW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(TAPS - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRot  = 2'd1;
  localparam logic [1:0] StLast = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]            state_d, state_q;
  logic [CntW-1:0]       cnt_d, cnt_q;
  logic signed [31:0]    prod_d, prod_q;
  logic                  pv_d, pv_q;
  logic [31:0]           acc_d, acc_q;
  logic [15:0]           out_d, out_q;
  logic                  ov_d, ov_q;
  logic                  in_acc;
  firfc_pkg::ctrl_t      ctrl;

  firfc_pkg::sample_t    in_sample, in_coeff;
  logic [firfc_pkg::IndexW-1:0] in_index;
  firfc_pkg::sample_t    sample_w [TAPS];
  firfc_pkg::sample_t    coeff_w  [TAPS];

  assign in_sample = s_axis_tdata[15:0];
  assign in_index  = s_axis_tdata[22:16];
  assign in_coeff  = s_axis_tdata[38:23];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ctrl.push     = in_acc && (s_axis_tuser == firfc_pkg::FuncSample);
  assign ctrl.wr       = in_acc && (s_axis_tuser == firfc_pkg::FuncCoeff);
  assign ctrl.rot      = (state_q == StRot);
  assign ctrl.wr_idx   = firfc_pkg::TapIdxW'(in_index);
  assign ctrl.wr_value = in_coeff;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    firfc_pkg::sample_t push_src;
    if (k == 0) begin : g_head
      assign push_src = in_sample;
    end else begin : g_body
      assign push_src = sample_w[k-1];
    end
    firfc_cell #(
      .IDX (k)
    ) u_tap (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .push_sample_i (push_src),
      .rot_sample_i  (sample_w[(k + 1) % TAPS]),
      .rot_coeff_i   (coeff_w[(k + 1) % TAPS]),
      .sample_o      (sample_w[k]),
      .coeff_o       (coeff_w[k])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    pv_d    = 1'b0;
    acc_d   = pv_q ? (acc_q + prod_q) : acc_q;
    out_d   = out_q;
    ov_d    = ov_q && !m_axis_tready;
    case (state_q)
      StIdle: begin
        if (ctrl.push) begin
          acc_d   = '0;
          cnt_d   = '0;
          state_d = StRot;
        end
      end
      StRot: begin
        prod_d = 32'(coeff_w[0]) * 32'(sample_w[0]);
        pv_d   = 1'b1;
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = StLast;
        end
      end
      StLast: begin
        state_d = StDone;
      end
      StDone: begin
        if (!ov_q || m_axis_tready) begin
          out_d   = acc_q[firfc_pkg::OutShift +: 16];
          ov_d    = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

endmodule

/* sv/firfc_cell.sv */
`timescale 1ns / 1ps
// one tap cell: a sample and a coefficient, shifted or rotated along the ring
module firfc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  firfc_pkg::ctrl_t  ctrl_i,
  input  firfc_pkg::sample_t push_sample_i,
  input  firfc_pkg::sample_t rot_sample_i,
  input  firfc_pkg::sample_t rot_coeff_i,
  output firfc_pkg::sample_t sample_o,
  output firfc_pkg::sample_t coeff_o
);

  localparam logic [firfc_pkg::TapIdxW-1:0] IdxBits = firfc_pkg::TapIdxW'(IDX);

  firfc_pkg::sample_t sample_d, sample_q;
  firfc_pkg::sample_t coeff_d, coeff_q;

  always_comb begin
    sample_d = sample_q;
    coeff_d  = coeff_q;
    if (ctrl_i.push) begin
      sample_d = push_sample_i;
    end else if (ctrl_i.rot) begin
      sample_d = rot_sample_i;
      coeff_d  = rot_coeff_i;
    end else if (ctrl_i.wr && (ctrl_i.wr_idx == IdxBits)) begin
      coeff_d = ctrl_i.wr_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      coeff_q  <= '0;
    end else begin
      sample_q <= sample_d;
      coeff_q  <= coeff_d;
    end
  end

  assign sample_o = sample_q;
  assign coeff_o  = coeff_q;

endmodule
